// ----- hw/rtl/pgbt_pkg.sv -----
// shared types and constants of the periodic grid bucket table
`default_nettype none

package pgbt_pkg;

    // grid and bucket geometry
    localparam int GRID_X     = 16;
    localparam int GRID_Y     = 16;
    localparam int BUCKET_CAP = 8;

    // fixed field widths
    localparam int ID_W       = 10;
    localparam int COORD_W    = 16;
    localparam int CELL_IDX_W = 8;
    localparam int FILL_W     = 4;

    // derived storage widths
    localparam int NUM_CELLS   = GRID_X * GRID_Y;
    localparam int CELL_W      = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int SLOT_W      = (BUCKET_CAP > 1) ? $clog2(BUCKET_CAP) : 1;
    localparam int CNT_W       = $clog2(BUCKET_CAP + 1);
    localparam int STORE_DEPTH = NUM_CELLS << SLOT_W;

    // wrap unit: remainder width and radix of the iterative modulo
    localparam int GRID_MAX   = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int REM_W      = $clog2(GRID_MAX) + 2;
    localparam int MOD_STEPS  = 4;
    localparam int MOD_CYCLES = COORD_W / MOD_STEPS;
    localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    // coordinates are offset by half range to become unsigned; these undo the offset
    localparam int X_CORR = (GRID_X - ((2 ** (COORD_W - 1)) % GRID_X)) % GRID_X;
    localparam int Y_CORR = (GRID_Y - ((2 ** (COORD_W - 1)) % GRID_Y)) % GRID_Y;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        t_opcode                    opcode;
        logic [ID_W-1:0]            walker_id;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
    } t_request;

    typedef struct packed {
        logic [CELL_IDX_W-1:0] cell_index;
        t_status               status;
        logic [FILL_W-1:0]     bucket_fill;
    } t_result;

endpackage

`default_nettype wire

// ----- hw/rtl/pgbt_ram.sv -----
// generic simple dual-port ram with registered read
`default_nettype none

module pgbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/periodic_grid_bucket_table_core.sv -----
// periodic grid bucket table: per-cell walker buckets with insert and swap-remove
`default_nettype none

// Keeps a bucket of walker ids for every cell of a periodic grid. A request is
// taken when start is high and busy is low; exactly one result follows on
// o_result, marked by o_result_valid for one cycle, and it cannot be held off.
// The signed coordinates are wrapped into the grid by an iterative modulo unit
// that retires four bits per cycle. The cell's fill count lives in a small ram
// with a valid bit per cell (cleared at reset, so there is no clearing pass);
// the slots live in a second ram with one read and one write port. A remove
// searches the bucket one slot per cycle through the slot ram read port. A
// full-bucket insert is refused with status full, an absent walker gives
// status not found; neither changes state. The result strobe shows in the
// same cycle in which busy drops, so the next request may be issued while a
// result is on the ports.
module periodic_grid_bucket_table_core
    import pgbt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_request i_request,
    output logic          o_result_valid,
    output t_result       o_result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,    // iterative wrap of both coordinates
        ST_CELL,   // final correction and linear cell index
        ST_CRD,    // count ram read issued
        ST_CWT,    // count available, insert or start search
        ST_SRCH,   // pipelined slot search for the walker id
        ST_MVRD,   // read the bucket's last slot
        ST_MVWR    // move last slot into the hole, store new count
    } t_state;

    t_state                r_state, n_state;
    logic                  r_strobe, n_strobe;
    t_result               r_result, n_result;
    logic [NUM_CELLS-1:0]  r_cvalid;

    // request payload and working registers
    t_opcode               r_op, n_op;
    logic [ID_W-1:0]       r_id, n_id;
    logic [COORD_W-1:0]    r_ux, n_ux, r_uy, n_uy;
    logic [REM_W-1:0]      r_mx, n_mx, r_my, n_my;
    logic [MOD_CNT_W-1:0]  r_step, n_step;
    logic [CELL_W-1:0]     r_cell, n_cell;
    logic                  r_cvld, n_cvld;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_k, n_k;
    logic                  r_qv, n_qv;
    logic [SLOT_W-1:0]     r_qk, n_qk;
    logic [SLOT_W-1:0]     r_hit, n_hit;

    // wrap unit datapath
    logic [COORD_W-1:0]    mod_ux, mod_uy;
    logic [REM_W-1:0]      mod_mx, mod_my;
    logic [REM_W-1:0]      wx_sum, wy_sum, wx, wy;
    logic [CELL_W-1:0]     cell_calc;

    // ram ports
    logic [CELL_W+SLOT_W-1:0] st_raddr, st_waddr;
    logic                     st_we;
    logic [ID_W-1:0]          st_wdata, st_q;
    logic                     ct_we;
    logic [CNT_W-1:0]         ct_wdata, ct_q;
    logic [CNT_W-1:0]         cnt_now;

    pgbt_ram #(
        .WIDTH (ID_W),
        .DEPTH (STORE_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_raddr (st_raddr),
        .o_rdata (st_q)
    );

    pgbt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_CELLS)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ct_we),
        .i_waddr (r_cell),
        .i_wdata (ct_wdata),
        .i_raddr (r_cell),
        .o_rdata (ct_q)
    );

    // restoring modulo, MOD_STEPS bits per cycle for x and y side by side
    always_comb begin
        mod_ux = r_ux;
        mod_uy = r_uy;
        mod_mx = r_mx;
        mod_my = r_my;
        for (int s = 0; s < MOD_STEPS; s++) begin
            mod_mx = {mod_mx[REM_W-2:0], mod_ux[COORD_W-1]};
            mod_my = {mod_my[REM_W-2:0], mod_uy[COORD_W-1]};
            mod_ux = {mod_ux[COORD_W-2:0], 1'b0};
            mod_uy = {mod_uy[COORD_W-2:0], 1'b0};
            if (mod_mx >= REM_W'(GRID_X)) begin
                mod_mx = mod_mx - REM_W'(GRID_X);
            end
            if (mod_my >= REM_W'(GRID_Y)) begin
                mod_my = mod_my - REM_W'(GRID_Y);
            end
        end
    end

    // undo the half-range offset, then form the linear cell index
    always_comb begin
        wx_sum    = r_mx + REM_W'(X_CORR);
        wy_sum    = r_my + REM_W'(Y_CORR);
        wx        = (wx_sum >= REM_W'(GRID_X)) ? wx_sum - REM_W'(GRID_X) : wx_sum;
        wy        = (wy_sum >= REM_W'(GRID_Y)) ? wy_sum - REM_W'(GRID_Y) : wy_sum;
        cell_calc = CELL_W'(wx) * CELL_W'(GRID_Y) + CELL_W'(wy);
    end

    // an untouched cell reads as an empty bucket
    assign cnt_now = r_cvld ? ct_q : '0;

    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_result = r_result;
        n_op     = r_op;
        n_id     = r_id;
        n_ux     = r_ux;
        n_uy     = r_uy;
        n_mx     = r_mx;
        n_my     = r_my;
        n_step   = r_step;
        n_cell   = r_cell;
        n_cvld   = r_cvld;
        n_cnt    = r_cnt;
        n_k      = r_k;
        n_qv     = r_qv;
        n_qk     = r_qk;
        n_hit    = r_hit;

        st_raddr = {r_cell, r_k[SLOT_W-1:0]};
        st_we    = 1'b0;
        st_waddr = {r_cell, r_cnt[SLOT_W-1:0]};
        st_wdata = r_id;
        ct_we    = 1'b0;
        ct_wdata = r_cnt;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_op   = i_request.opcode;
                    n_id   = i_request.walker_id;
                    // offset by half range: signed value becomes unsigned
                    n_ux   = {~i_request.coord_x[COORD_W-1], i_request.coord_x[COORD_W-2:0]};
                    n_uy   = {~i_request.coord_y[COORD_W-1], i_request.coord_y[COORD_W-2:0]};
                    n_mx   = '0;
                    n_my   = '0;
                    n_step = '0;
                    n_state = ST_MOD;
                end
            end
            ST_MOD: begin
                n_ux   = mod_ux;
                n_uy   = mod_uy;
                n_mx   = mod_mx;
                n_my   = mod_my;
                n_step = r_step + MOD_CNT_W'(1);
                if (r_step == MOD_CNT_W'(MOD_CYCLES - 1)) begin
                    n_state = ST_CELL;
                end
            end
            ST_CELL: begin
                n_cell  = cell_calc;
                n_state = ST_CRD;
            end
            ST_CRD: begin
                n_cvld  = r_cvalid[r_cell];
                n_state = ST_CWT;
            end
            ST_CWT: begin
                n_cnt = cnt_now;
                if (r_op == OP_INSERT) begin
                    n_strobe             = 1'b1;
                    n_result.cell_index  = CELL_IDX_W'(r_cell);
                    n_state              = ST_IDLE;
                    if (cnt_now >= CNT_W'(BUCKET_CAP)) begin
                        n_result.status      = STAT_FULL;
                        n_result.bucket_fill = FILL_W'(cnt_now);
                    end else begin
                        st_we                = 1'b1;
                        st_waddr             = {r_cell, cnt_now[SLOT_W-1:0]};
                        ct_we                = 1'b1;
                        ct_wdata             = cnt_now + CNT_W'(1);
                        n_result.status      = STAT_DONE;
                        n_result.bucket_fill = FILL_W'(cnt_now + CNT_W'(1));
                    end
                end else if (cnt_now == '0) begin
                    n_strobe             = 1'b1;
                    n_result.cell_index  = CELL_IDX_W'(r_cell);
                    n_result.status      = STAT_NOT_FOUND;
                    n_result.bucket_fill = '0;
                    n_state              = ST_IDLE;
                end else begin
                    n_k     = '0;
                    n_qv    = 1'b0;
                    n_state = ST_SRCH;
                end
            end
            ST_SRCH: begin
                // one slot read issued per cycle, compared in the cycle after
                n_qv = (r_k < r_cnt);
                n_qk = r_k[SLOT_W-1:0];
                if (r_k < r_cnt) begin
                    n_k = r_k + CNT_W'(1);
                end
                if (r_qv && (st_q == r_id)) begin
                    n_hit   = r_qk;
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = ST_MVRD;
                end else if (r_qv && ((CNT_W'(r_qk) + CNT_W'(1)) == r_cnt)) begin
                    n_strobe             = 1'b1;
                    n_result.cell_index  = CELL_IDX_W'(r_cell);
                    n_result.status      = STAT_NOT_FOUND;
                    n_result.bucket_fill = FILL_W'(r_cnt);
                    n_state              = ST_IDLE;
                end
            end
            ST_MVRD: begin
                // r_cnt now indexes the last slot
                st_raddr = {r_cell, r_cnt[SLOT_W-1:0]};
                n_state  = ST_MVWR;
            end
            ST_MVWR: begin
                st_we                = 1'b1;
                st_waddr             = {r_cell, r_hit};
                st_wdata             = st_q;
                ct_we                = 1'b1;
                ct_wdata             = r_cnt;
                n_strobe             = 1'b1;
                n_result.cell_index  = CELL_IDX_W'(r_cell);
                n_result.status      = STAT_DONE;
                n_result.bucket_fill = FILL_W'(r_cnt);
                n_state              = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
        r_op     <= n_op;
        r_id     <= n_id;
        r_ux     <= n_ux;
        r_uy     <= n_uy;
        r_mx     <= n_mx;
        r_my     <= n_my;
        r_cell   <= n_cell;
        r_cvld   <= n_cvld;
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_qk     <= n_qk;
        r_hit    <= n_hit;
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_step   <= '0;
            r_qv     <= 1'b0;
            r_cvalid <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_step   <= n_step;
            r_qv     <= n_qv;
            if (ct_we) begin
                r_cvalid[r_cell] <= 1'b1;
            end
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_strobe;
    assign o_result       = r_result;

endmodule

`default_nettype wire

// ----- hw/rtl/pgbt_chk.sv -----
// port-level checker for the periodic grid bucket table, bound to the top level
`default_nettype none

module pgbt_chk
    import pgbt_pkg::*;
(
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_result_valid,
    input wire t_result o_result
);

    // a taken request keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    // a result is only shown once the block has finished
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result shown while busy");

    // one result per request: strobe lasts a single cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");

    // every end of work delivers a result
    a_finish_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("work finished without a result");

    // a refused insert reports a full bucket
    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_result.status == STAT_FULL))
            |-> (o_result.bucket_fill == FILL_W'(BUCKET_CAP)))
        else $error("full status with bucket not full");

endmodule

bind periodic_grid_bucket_table_core pgbt_chk u_pgbt_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result)
);

`default_nettype wire
